FILE: hw/rtl/rhc_pkg.sv
// Shared types and byte constants for the relaxed header canonicalizer.
`default_nettype none

package rhc_pkg;

    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CASE_OFFSET  = 8'h20;
    localparam logic [7:0] CHAR_COLON   = 8'h3A;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_TAB     = 8'h09;
    localparam logic [7:0] CHAR_CR      = 8'h0D;
    localparam logic [7:0] CHAR_LF      = 8'h0A;

    // Output buffer depth and its count width
    localparam int unsigned OBUF_DEPTH = 4;
    localparam int unsigned OBUF_PTR_W = 2;
    localparam int unsigned OBUF_CNT_W = 3;

    typedef struct packed {
        logic [7:0] data;
        logic       valid;
        logic       last;
    } rhc_res_t;

    // Up to two results produced by one input byte
    typedef struct packed {
        logic [1:0] cnt;
        rhc_res_t   res0;
        rhc_res_t   res1;
    } rhc_pair_t;

endpackage

`default_nettype wire

FILE: hw/rtl/relaxed_header_canonicalizer.sv
// Top level of the relaxed header canonicalizer.
`default_nettype none

// Relaxed header canonicalizer: one header field enters as a byte stream
// (s_tlast on its final byte). Whitespace runs fold to one space emitted only
// before a following non-whitespace byte, trailing runs are dropped, letters
// before the first colon are lowercased and a space right after that colon is
// removed. A trailing whitespace byte with s_tlast yields a bare end marker
// (m_tuser low, m_tdata zero, m_tlast high). One byte is accepted per cycle
// while the four-entry output queue has room. A byte that needs a folded
// space in front produces two requests, but the output side drains only one
// request per cycle. The queue takes a pair only when room exists without
// counting the request leaving in the same cycle. Input therefore stalls
// while m_tready is low. It also stalls when extra spaces arrive faster than
// the queue drains: each extra space needs an output transfer of its own,
// and a two-request byte waits whenever the queue already holds three
// requests. The path from input to output runs through the input register,
// then the output queue.
module relaxed_header_canonicalizer (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] in_byte
    input  wire logic       s_tlast,
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // [7:0] out_byte
    output logic            m_tuser,   // [0] out_valid
    output logic            m_tlast
);
    import rhc_pkg::*;

    rhc_pair_t pair;
    logic      pair_valid;
    logic      pair_take;
    rhc_res_t  out_res;

    rhc_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_byte    (s_tdata),
        .in_last    (s_tlast),
        .pair       (pair),
        .pair_valid (pair_valid),
        .pair_take  (pair_take)
    );

    rhc_obuf u_obuf (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .pair       (pair),
        .pair_valid (pair_valid),
        .pair_take  (pair_take),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_res    (out_res)
    );

    assign m_tdata = out_res.data;
    assign m_tuser = out_res.valid;
    assign m_tlast = out_res.last;

endmodule

`default_nettype wire

FILE: hw/rtl/rhc_core.sv
// Input register, canonicalizer state and per-byte result logic.
`default_nettype none

module rhc_core (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [7:0]        in_byte,
    input  wire logic              in_last,
    output rhc_pkg::rhc_pair_t     pair,
    output logic                   pair_valid,
    input  wire logic              pair_take
);
    import rhc_pkg::*;

    logic       hold_valid_reg;
    logic       hold_valid_next;
    logic [7:0] hold_byte_reg;
    logic       hold_last_reg;

    logic space_pending_reg, space_pending_next;
    logic colon_seen_reg, colon_seen_next;
    logic just_after_colon_reg, just_after_colon_next;

    logic       is_ws;
    logic       emit_space;
    logic       first_colon;
    logic [7:0] byte_fixed;
    rhc_res_t   res_space;
    rhc_res_t   res_byte;
    rhc_res_t   res_end;

    assign pair_valid = hold_valid_reg;
    assign in_ready   = !hold_valid_reg || pair_take;

    always_comb begin
        is_ws = (hold_byte_reg == CHAR_SPACE) || (hold_byte_reg == CHAR_TAB) ||
                (hold_byte_reg == CHAR_CR) || (hold_byte_reg == CHAR_LF);
        emit_space = space_pending_reg && !just_after_colon_reg;
        byte_fixed = hold_byte_reg;
        if (!colon_seen_reg && hold_byte_reg >= CHAR_UPPER_A &&
            hold_byte_reg <= CHAR_UPPER_Z) begin
            byte_fixed = hold_byte_reg + CASE_OFFSET;
        end
        first_colon = !colon_seen_reg && (hold_byte_reg == CHAR_COLON);

        res_space = '{data: CHAR_SPACE, valid: 1'b1, last: 1'b0};
        res_byte  = '{data: byte_fixed, valid: 1'b1, last: hold_last_reg};
        res_end   = '{data: 8'h00, valid: 1'b0, last: 1'b1};

        if (is_ws) begin
            pair.cnt  = hold_last_reg ? 2'd1 : 2'd0;
            pair.res0 = res_end;
            pair.res1 = res_end;
        end else if (emit_space) begin
            pair.cnt  = 2'd2;
            pair.res0 = res_space;
            pair.res1 = res_byte;
        end else begin
            pair.cnt  = 2'd1;
            pair.res0 = res_byte;
            pair.res1 = res_byte;
        end

        space_pending_next    = space_pending_reg;
        colon_seen_next       = colon_seen_reg;
        just_after_colon_next = just_after_colon_reg;
        if (hold_valid_reg && pair_take) begin
            if (hold_last_reg) begin
                space_pending_next    = 1'b0;
                colon_seen_next       = 1'b0;
                just_after_colon_next = 1'b0;
            end else if (is_ws) begin
                space_pending_next = 1'b1;
            end else begin
                space_pending_next    = 1'b0;
                colon_seen_next       = colon_seen_reg || first_colon;
                just_after_colon_next = first_colon;
            end
        end

        hold_valid_next = hold_valid_reg;
        if (in_ready) begin
            hold_valid_next = in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg       <= 1'b0;
            space_pending_reg    <= 1'b0;
            colon_seen_reg       <= 1'b0;
            just_after_colon_reg <= 1'b0;
        end else begin
            hold_valid_reg       <= hold_valid_next;
            space_pending_reg    <= space_pending_next;
            colon_seen_reg       <= colon_seen_next;
            just_after_colon_reg <= just_after_colon_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            hold_byte_reg <= in_byte;
            hold_last_reg <= in_last;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/rhc_obuf.sv
// Small output queue taking up to two results per cycle while it has room, releasing one while out_ready is high.
`default_nettype none

module rhc_obuf (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire rhc_pkg::rhc_pair_t pair,
    input  wire logic               pair_valid,
    output logic                    pair_take,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output rhc_pkg::rhc_res_t       out_res
);
    import rhc_pkg::*;

    rhc_res_t                mem_reg [OBUF_DEPTH];
    logic [OBUF_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [OBUF_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [OBUF_CNT_W-1:0]   cnt_reg, cnt_next;
    logic [OBUF_CNT_W-1:0]   free_slots;
    logic [OBUF_CNT_W-1:0]   wr_cnt;
    logic                    pop;
    logic [OBUF_PTR_W-1:0]   wr_ptr_plus1;

    assign out_valid    = (cnt_reg != '0);
    assign out_res      = mem_reg[rd_ptr_reg];
    assign pop          = out_valid && out_ready;
    // Count frees only from the queue's current contents, so no path
    // runs from out_ready through to the input side.
    assign free_slots   = OBUF_CNT_W'(OBUF_DEPTH) - cnt_reg;
    assign pair_take    = pair_valid && ({1'b0, pair.cnt} <= free_slots);
    assign wr_cnt       = pair_take ? {1'b0, pair.cnt} : '0;
    assign wr_ptr_plus1 = wr_ptr_reg + 1'b1;

    always_comb begin
        wr_ptr_next = wr_ptr_reg + wr_cnt[OBUF_PTR_W-1:0];
        rd_ptr_next = rd_ptr_reg + (pop ? 1'b1 : 1'b0);
        cnt_next    = cnt_reg + wr_cnt - (pop ? OBUF_CNT_W'(1) : '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_cnt != '0) begin
            mem_reg[wr_ptr_reg] <= pair.res0;
        end
        if (wr_cnt == OBUF_CNT_W'(2)) begin
            mem_reg[wr_ptr_plus1] <= pair.res1;
        end
    end

endmodule

`default_nettype wire
